@@ sv/vpfu_pkg.sv @@
// Shared constants and types of the virtual-pipe flux update unit.
package vpfu_pkg;

    localparam int unsigned IN_TDATA_W  = 352;
    localparam int unsigned IN_TUSER_W  = 4;
    localparam int unsigned OUT_TDATA_W = 128;
    localparam int unsigned ADDR_W      = 4;
    localparam int unsigned LANES       = 4;
    localparam int unsigned DIV_STAGES  = 8;
    localparam int unsigned DIV_STEPS   = 4;
    localparam int unsigned NSTG        = 6 + DIV_STAGES;
    localparam int unsigned DIV_BITS    = 80;

    localparam logic [31:0] PI_Q2_30        = 32'd3373259426;
    localparam logic [31:0] GRAVITY_RST     = 32'd642253;
    localparam logic [31:0] PIPE_LENGTH_RST = 32'd655360;
    localparam logic [31:0] PIPE_RADIUS_RST = 32'd65536;
    localparam logic [31:0] TIME_STEP_RST   = 32'd4294967;
    localparam logic [40:0] TERM_CAP        = 41'h100_0000_0000;

    typedef enum logic [1:0] {
        REG_GRAVITY,
        REG_PIPE_LENGTH,
        REG_PIPE_RADIUS,
        REG_TIME_STEP
    } t_reg_idx;

endpackage

@@ sv/virtual_pipe_flux_update_unit.sv @@
// Virtual-pipe outflow flux update: coefficient sequencer and 14-stage cell pipeline.
//
//  channel   | dir | handshake                     | payload
//  s_axis    | in  | s_axis_tvalid/s_axis_tready   | tdata 352 bits, tuser edge_mask
//  m_axis    | out | m_axis_tvalid/m_axis_tready   | tdata 128 bits, four new fluxes
//  apb cfg   | in  | psel/penable/pwrite/pready    | paddr 4 bits, pwdata/prdata 32 bits
//
//  One cell per cycle unless the sequencer is busy or a stalled output has filled the pipeline.
//  Alpha and beta come from a sequencer with one bit-serial divider: it reruns
//  after reset and after every register write, with s_axis_tready low meanwhile.
//  Each stage advances into a free slot; a held output register stalls upstream
//  only once the bubbles in front of it are used up.
module virtual_pipe_flux_update_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // rock, soil, water, height_left/up/right/down,
    // prev_flux_left/up/right/down, zero pad
    input  logic [vpfu_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // edge_mask
    input  logic [vpfu_pkg::IN_TUSER_W-1:0] s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // new_flux_left/up/right/down, zero pad
    output logic [vpfu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vpfu_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import vpfu_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ACC, ST_DIV} t_state;
    typedef enum logic [2:0] {
        OP_RR, OP_PI, OP_G, OP_DT, OP_ALPHA, OP_LL, OP_BETA
    } t_op;

    // configuration
    logic        w_cfg_wr;
    logic [31:0] r_gravity, r_pipe_length, r_pipe_radius, r_time_step;

    assign w_cfg_wr = psel & penable & pwrite;
    assign pready   = 1'b1;

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_GRAVITY:     prdata = r_gravity;
            REG_PIPE_LENGTH: prdata = r_pipe_length;
            REG_PIPE_RADIUS: prdata = r_pipe_radius;
            REG_TIME_STEP:   prdata = r_time_step;
            default:         prdata = '0;
        endcase
    end

    // coefficient sequencer
    t_state      r_state;
    t_op         r_op;
    logic [63:0] r_x, r_alpha, r_beta, r_ph, r_pl;
    logic [63:0] n_ph, n_pl;
    logic [79:0] r_dsh, n_dsh;
    logic [31:0] r_drem, n_drem;
    logic [6:0]  r_dcnt;
    logic [63:0] w_ma, w_sat, w_dres;
    logic [31:0] w_mb, w_len_nz, w_dt_nz, w_div;
    logic [95:0] w_prod, w_shf;
    logic [32:0] w_dtry;
    logic        w_dbit, w_busy;

    assign w_len_nz = (r_pipe_length == 32'd0) ? 32'd1 : r_pipe_length;
    assign w_dt_nz  = (r_time_step == 32'd0) ? 32'd1 : r_time_step;
    assign w_busy   = (r_state != ST_IDLE);

    always_comb begin
        case (r_op)
            OP_RR:   begin w_ma = {32'd0, r_pipe_radius}; w_mb = r_pipe_radius; end
            OP_PI:   begin w_ma = r_x; w_mb = PI_Q2_30; end
            OP_G:    begin w_ma = r_x; w_mb = r_gravity; end
            OP_DT:   begin w_ma = r_x; w_mb = r_time_step; end
            OP_LL:   begin w_ma = {32'd0, w_len_nz}; w_mb = w_len_nz; end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
        n_ph   = w_ma[63:32] * w_mb;
        n_pl   = w_ma[31:0] * w_mb;
        w_prod = {r_ph, 32'd0} + {32'd0, r_pl};
        case (r_op)
            OP_PI:   w_shf = w_prod >> 30;
            OP_G:    w_shf = w_prod >> 16;
            OP_DT:   w_shf = w_prod >> 32;
            default: w_shf = w_prod;
        endcase
        w_sat  = (|w_shf[95:64]) ? '1 : w_shf[63:0];
        w_div  = (r_op == OP_ALPHA) ? w_len_nz : w_dt_nz;
        w_dtry = {r_drem, r_dsh[79]};
        w_dbit = (w_dtry >= {1'b0, w_div});
        n_drem = w_dbit ? 32'(w_dtry - {1'b0, w_div}) : w_dtry[31:0];
        n_dsh  = {r_dsh[78:0], w_dbit};
        w_dres = (|n_dsh[79:64]) ? '1 : n_dsh[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity     <= GRAVITY_RST;
            r_pipe_length <= PIPE_LENGTH_RST;
            r_pipe_radius <= PIPE_RADIUS_RST;
            r_time_step   <= TIME_STEP_RST;
            r_state       <= ST_MUL;
            r_op          <= OP_RR;
        end else if (w_cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_GRAVITY:     r_gravity     <= pwdata;
                REG_PIPE_LENGTH: r_pipe_length <= pwdata;
                REG_PIPE_RADIUS: r_pipe_radius <= pwdata;
                REG_TIME_STEP:   r_time_step   <= pwdata;
                default: ;
            endcase
            r_state <= ST_MUL;
            r_op    <= OP_RR;
        end else begin
            case (r_state)
                ST_MUL: begin
                    r_ph    <= n_ph;
                    r_pl    <= n_pl;
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_x <= w_sat;
                    if (r_op == OP_DT || r_op == OP_LL) begin
                        r_op    <= (r_op == OP_DT) ? OP_ALPHA : OP_BETA;
                        r_dsh   <= {w_sat, 16'd0};
                        r_drem  <= '0;
                        r_dcnt  <= '0;
                        r_state <= ST_DIV;
                    end else begin
                        r_op    <= t_op'(r_op + 3'd1);
                        r_state <= ST_MUL;
                    end
                end
                ST_DIV: begin
                    r_dsh  <= n_dsh;
                    r_drem <= n_drem;
                    r_dcnt <= r_dcnt + 7'd1;
                    if (r_dcnt == 7'(DIV_BITS - 1)) begin
                        if (r_op == OP_ALPHA) begin
                            r_alpha <= w_dres;
                            r_op    <= OP_LL;
                            r_state <= ST_MUL;
                        end else begin
                            r_beta  <= w_dres;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // cell pipeline flow control
    logic [NSTG:1]   r_vld;
    logic [NSTG+1:1] w_en;
    logic            w_acc;

    always_comb begin
        w_en[NSTG+1] = m_axis_tready;
        for (int k = NSTG; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[1] && !w_busy && !w_cfg_wr;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= w_acc;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: centre height
    logic [31:0] w_in_h [LANES];
    logic [30:0] w_in_prev [LANES];
    logic [33:0] w_hsum;
    logic [31:0] n1_hc;
    logic [31:0] r1_hc;
    logic [31:0] r1_h [LANES];
    logic [30:0] r1_prev [LANES];
    logic [3:0]  r1_mask;
    logic [30:0] r1_water;

    assign w_in_h[0]    = s_axis_tdata[126:95];
    assign w_in_h[1]    = s_axis_tdata[158:127];
    assign w_in_h[2]    = s_axis_tdata[190:159];
    assign w_in_h[3]    = s_axis_tdata[222:191];
    assign w_in_prev[0] = s_axis_tdata[253:223];
    assign w_in_prev[1] = s_axis_tdata[284:254];
    assign w_in_prev[2] = s_axis_tdata[315:285];
    assign w_in_prev[3] = s_axis_tdata[346:316];

    always_comb begin
        w_hsum = {{2{s_axis_tdata[31]}}, s_axis_tdata[31:0]}
               + {{2{s_axis_tdata[63]}}, s_axis_tdata[63:32]}
               + {3'd0, s_axis_tdata[94:64]};
        if (w_hsum[33] && w_hsum[32:31] != 2'b11) begin
            n1_hc = 32'h8000_0000;
        end else if (!w_hsum[33] && w_hsum[32:31] != 2'b00) begin
            n1_hc = 32'h7FFF_FFFF;
        end else begin
            n1_hc = w_hsum[31:0];
        end
    end

    // stage 2: height drop
    logic [32:0] w_drop [LANES];
    logic [31:0] n2_mag [LANES];
    logic [31:0] r2_mag [LANES];
    logic [3:0]  r2_neg;
    logic [30:0] r2_prev [LANES];
    logic [30:0] r2_water;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            w_drop[j] = {r1_hc[31], r1_hc}
                      - (r1_mask[j] ? {r1_h[j][31], r1_h[j]} : {r1_hc[31], r1_hc});
            n2_mag[j] = w_drop[j][32] ? 32'(33'd0 - w_drop[j]) : w_drop[j][31:0];
        end
    end

    // stage 3: alpha and beta products
    logic [63:0] n3_ph [LANES];
    logic [63:0] w_pl [LANES];
    logic [63:0] r3_ph [LANES];
    logic [31:0] r3_plh [LANES];
    logic [3:0]  r3_neg;
    logic [30:0] r3_prev [LANES];
    logic [62:0] n3_wbh, n3_wbl, r3_wbh, r3_wbl;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            n3_ph[j] = r_alpha[63:32] * r2_mag[j];
            w_pl[j]  = r_alpha[31:0] * r2_mag[j];
        end
        n3_wbh = r2_water * r_beta[63:32];
        n3_wbl = r2_water * r_beta[31:0];
    end

    // stage 4: flux update and outflow limit
    logic [64:0] w_tsum [LANES];
    logic [40:0] w_term [LANES];
    logic [41:0] w_v [LANES];
    logic [30:0] n4_f [LANES];
    logic [30:0] r4_f [LANES];
    logic [79:0] w_nfull;
    logic [33:0] n4_num, r4_num;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            w_tsum[j] = {1'b0, r3_ph[j]} + {33'd0, r3_plh[j]};
            w_term[j] = (w_tsum[j] >= {24'd0, TERM_CAP}) ? TERM_CAP : w_tsum[j][40:0];
            w_v[j]    = {11'd0, r3_prev[j]} + {1'b0, w_term[j]};
            if (r3_neg[j]) begin
                n4_f[j] = (w_term[j] > {10'd0, r3_prev[j]})
                        ? 31'd0 : 31'({10'd0, r3_prev[j]} - w_term[j]);
            end else begin
                n4_f[j] = (|w_v[j][41:31]) ? '1 : w_v[j][30:0];
            end
        end
        w_nfull = {1'b0, r3_wbh, 16'd0} + {33'd0, r3_wbl[62:16]};
        n4_num  = (|w_nfull[79:34]) ? '1 : w_nfull[33:0];
    end

    // stage 5: flux sum
    logic [32:0] n5_sum, r5_sum;
    logic [30:0] r5_f [LANES];
    logic [33:0] r5_num;

    assign n5_sum = {2'd0, r4_f[0]} + {2'd0, r4_f[1]} + {2'd0, r4_f[2]} + {2'd0, r4_f[3]};

    // stage 6: scale test and dividends
    logic        n6_pass, r6_pass;
    logic [63:0] n6_n [LANES];
    logic [63:0] r6_n [LANES];
    logic [30:0] r6_f [LANES];
    logic [32:0] r6_sum;

    always_comb begin
        n6_pass = (r5_num >= {1'b0, r5_sum});
        for (int j = 0; j < LANES; j++) begin
            n6_n[j] = r5_f[j] * r5_num[32:0];
        end
    end

    // stages 7..14: restoring division, four quotient bits per stage
    logic [32:0] r_dv_rem [DIV_STAGES][LANES];
    logic [31:0] r_dv_sh  [DIV_STAGES][LANES];
    logic [30:0] r_dv_f   [DIV_STAGES][LANES];
    logic [32:0] r_dv_sum [DIV_STAGES];
    logic        r_dv_pass [DIV_STAGES];
    logic [32:0] n_dv_rem [DIV_STAGES][LANES];
    logic [31:0] n_dv_sh  [DIV_STAGES][LANES];

    always_comb begin
        logic [32:0] v_rem;
        logic [31:0] v_sh;
        logic [33:0] v_try;
        logic [32:0] v_sum;
        logic        v_bit;
        for (int s = 0; s < DIV_STAGES; s++) begin
            v_sum = (s == 0) ? r6_sum : r_dv_sum[(s == 0) ? 0 : s - 1];
            for (int j = 0; j < LANES; j++) begin
                if (s == 0) begin
                    v_rem = {1'b0, r6_n[j][63:32]};
                    v_sh  = r6_n[j][31:0];
                end else begin
                    v_rem = r_dv_rem[(s == 0) ? 0 : s - 1][j];
                    v_sh  = r_dv_sh[(s == 0) ? 0 : s - 1][j];
                end
                for (int t = 0; t < DIV_STEPS; t++) begin
                    v_try = {v_rem, v_sh[31]};
                    v_bit = (v_try >= {1'b0, v_sum});
                    v_rem = v_bit ? 33'(v_try - {1'b0, v_sum}) : v_try[32:0];
                    v_sh  = {v_sh[30:0], v_bit};
                end
                n_dv_rem[s][j] = v_rem;
                n_dv_sh[s][j]  = v_sh;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_hc    <= n1_hc;
            r1_h     <= w_in_h;
            r1_prev  <= w_in_prev;
            r1_mask  <= s_axis_tuser;
            r1_water <= s_axis_tdata[94:64];
        end
        if (w_en[2]) begin
            r2_mag   <= n2_mag;
            r2_prev  <= r1_prev;
            r2_water <= r1_water;
            for (int j = 0; j < LANES; j++) begin
                r2_neg[j] <= w_drop[j][32];
            end
        end
        if (w_en[3]) begin
            r3_ph   <= n3_ph;
            r3_neg  <= r2_neg;
            r3_prev <= r2_prev;
            r3_wbh  <= n3_wbh;
            r3_wbl  <= n3_wbl;
            for (int j = 0; j < LANES; j++) begin
                r3_plh[j] <= w_pl[j][63:32];
            end
        end
        if (w_en[4]) begin
            r4_f   <= n4_f;
            r4_num <= n4_num;
        end
        if (w_en[5]) begin
            r5_f   <= r4_f;
            r5_num <= r4_num;
            r5_sum <= n5_sum;
        end
        if (w_en[6]) begin
            r6_pass <= n6_pass;
            r6_n    <= n6_n;
            r6_f    <= r5_f;
            r6_sum  <= r5_sum;
        end
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (w_en[7+s]) begin
                r_dv_rem[s]  <= n_dv_rem[s];
                r_dv_sh[s]   <= n_dv_sh[s];
                r_dv_f[s]    <= (s == 0) ? r6_f : r_dv_f[(s == 0) ? 0 : s - 1];
                r_dv_sum[s]  <= (s == 0) ? r6_sum : r_dv_sum[(s == 0) ? 0 : s - 1];
                r_dv_pass[s] <= (s == 0) ? r6_pass : r_dv_pass[(s == 0) ? 0 : s - 1];
            end
        end
    end

    // output
    logic [30:0] w_out [LANES];

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            w_out[j] = r_dv_pass[DIV_STAGES-1] ? r_dv_f[DIV_STAGES-1][j]
                                               : r_dv_sh[DIV_STAGES-1][j][30:0];
        end
    end

    assign m_axis_tvalid = r_vld[NSTG];
    assign m_axis_tdata  = {4'd0, w_out[3], w_out[2], w_out[1], w_out[0]};

endmodule

@@ sv/vpfu_checker.sv @@
// Port-level checks of the virtual-pipe flux update unit and their bind.
module vpfu_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    // rock, soil, water, heights, previous fluxes, zero pad
    input logic [vpfu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // edge_mask
    input logic [vpfu_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    // new fluxes left, up, right, down, zero pad
    input logic [vpfu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [vpfu_pkg::ADDR_W-1:0]      paddr,
    input logic [31:0]                      pwdata,
    input logic [31:0]                      prdata,
    input logic                             pready
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result transaction dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready |=> !s_axis_tready)
        else $error("input taken while coefficients are recomputed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind virtual_pipe_flux_update_unit vpfu_checker u_vpfu_checker (.*);

@@ verif/tb.sv @@
// Self-checking testbench for virtual_pipe_flux_update_unit: stream traffic, APB setup, predictor.
module tb;
    import vpfu_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam logic [127:0] MAX64 = {64'd0, {64{1'b1}}};
    localparam logic [127:0] FLUX_TERM_CAP = 128'd1 << 40;
    localparam logic [127:0] NUM_CAP = 128'd1 << 62;
    localparam logic [30:0] FLUX_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [3:0]       mask;
        logic [31:0]      rock;
        logic [31:0]      soil;
        logic [30:0]      water;
        logic [3:0][31:0] height;
        logic [3:0][30:0] prev;
    } t_cell;

    typedef logic [3:0][30:0] t_flux4;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic [IN_TUSER_W-1:0]   s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    logic [31:0] cfg_gravity;
    logic [31:0] cfg_length;
    logic [31:0] cfg_radius;
    logic [31:0] cfg_dt;

    t_flux4      exp_fluxes[$];
    int unsigned fail_cnt;
    int unsigned idle_cycles;
    bit          calm;
    int unsigned rx_stall;

    t_cell  dir_cells[$];
    bit     dir_typed[$];
    t_flux4 dir_fluxes[$];

    virtual_pipe_flux_update_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [127:0] mul_floor(logic [127:0] a, logic [127:0] b, int s,
                                               logic [127:0] cap);
        logic [127:0] p;
        p = (a * b) >> s;
        return (p > cap) ? cap : p;
    endfunction

    function automatic logic [127:0] div_q16(logic [127:0] n, logic [127:0] d);
        logic [127:0] q;
        q = (n << 16) / d;
        return (q > MAX64) ? MAX64 : q;
    endfunction

    function automatic t_flux4 predict_flux(t_cell c);
        logic [127:0] len, dt, t, alpha, beta, mag, term, num, sum, scaled;
        longint hc, h, drop, v;
        longint f[4];
        t_flux4 res;
        len = (cfg_length == 0) ? 128'd1 : {96'd0, cfg_length};
        dt = (cfg_dt == 0) ? 128'd1 : {96'd0, cfg_dt};
        t = mul_floor({96'd0, cfg_radius} * {96'd0, cfg_radius}, {96'd0, PI_Q2_30}, 30, MAX64);
        t = mul_floor(t, {96'd0, cfg_gravity}, 16, MAX64);
        t = mul_floor(t, {96'd0, cfg_dt}, 32, MAX64);
        alpha = div_q16(t, len);
        beta = div_q16(len * len, dt);
        hc = longint'($signed(c.rock)) + longint'($signed(c.soil)) + longint'(c.water);
        if (hc > 64'sd2147483647) hc = 64'sd2147483647;
        if (hc < -64'sd2147483648) hc = -64'sd2147483648;
        sum = 0;
        for (int j = 0; j < 4; j++) begin
            h = c.mask[j] ? longint'($signed(c.height[j])) : hc;
            drop = hc - h;
            mag = (drop < 0) ? 128'(-drop) : 128'(drop);
            term = mul_floor(alpha, mag, 32, FLUX_TERM_CAP);
            v = longint'(c.prev[j]) + ((drop < 0) ? -longint'(term) : longint'(term));
            if (v < 0) v = 0;
            if (v > longint'(FLUX_MAX)) v = longint'(FLUX_MAX);
            f[j] = v;
            sum += 128'(v);
        end
        num = mul_floor({97'd0, c.water}, beta, 16, NUM_CAP);
        for (int j = 0; j < 4; j++) begin
            scaled = (num >= sum) ? 128'(f[j]) : (128'(f[j]) * num) / sum;
            res[j] = scaled[30:0];
        end
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_cell random_cell();
        t_cell c;
        int unsigned style;
        logic [31:0] base;
        style = $urandom_range(0, 3);
        c.mask = 4'($urandom_range(0, 15));
        c.rock = $urandom;
        c.soil = $urandom;
        c.water = 31'($urandom);
        for (int j = 0; j < 4; j++) begin
            c.height[j] = $urandom;
            c.prev[j] = 31'($urandom);
        end
        if (style != 0) begin
            c.rock = $urandom_range(0, 32'h00FF_FFFF);
            c.soil = $urandom_range(0, 32'h00FF_FFFF);
            c.water = (style == 1) ? 31'($urandom_range(0, 255))
                                   : 31'($urandom_range(0, 32'h003F_FFFF));
            base = c.rock + c.soil + c.water;
            for (int j = 0; j < 4; j++) begin
                c.height[j] = base + $urandom_range(0, 32'h01FF_FFFF) - 32'h00FF_FFFF;
                c.prev[j] = 31'($urandom_range(0, 32'h000F_FFFF));
            end
        end
        return c;
    endfunction

    task automatic send_cell(t_cell c, bit typed, t_flux4 typed_flux);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= c.mask;
        s_axis_tdata <= {5'd0, c.prev, c.height, c.water, c.soil, c.rock};
        exp_fluxes.push_back(typed ? typed_flux : predict_flux(c));
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic idle_input();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_GRAVITY:     cfg_gravity = value;
            REG_PIPE_LENGTH: cfg_length = value;
            REG_PIPE_RADIUS: cfg_radius = value;
            REG_TIME_STEP:   cfg_dt = value;
            default: ;
        endcase
    endtask

    task automatic drain();
        idle_input();
        wait (exp_fluxes.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_config(logic [31:0] g, logic [31:0] l, logic [31:0] r, logic [31:0] d);
        drain();
        write_reg(REG_GRAVITY, g);
        write_reg(REG_PIPE_LENGTH, l);
        write_reg(REG_PIPE_RADIUS, r);
        write_reg(REG_TIME_STEP, d);
    endtask

    task automatic add_row(logic [3:0] mask, logic [31:0] rock, logic [31:0] soil,
                           logic [30:0] water, logic [3:0][31:0] h, logic [3:0][30:0] p,
                           bit typed, t_flux4 e);
        t_cell c;
        c = '{mask: mask, rock: rock, soil: soil, water: water, height: h, prev: p};
        dir_cells.push_back(c);
        dir_typed.push_back(typed);
        dir_fluxes.push_back(e);
    endtask

    task automatic random_phase(int unsigned n, bit hold_midway);
        for (int unsigned i = 0; i < n; i++) begin
            if (i % 16 == 0) calm = ($urandom_range(0, 3) == 0);
            if (hold_midway && i == n / 2) begin
                idle_input();
                wait (exp_fluxes.size() == 0);
            end
            send_cell(random_cell(), 1'b0, '0);
        end
        calm = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_stall <= 0;
        end else if (rx_stall != 0) begin
            m_axis_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            m_axis_tready <= 1'b1;
            rx_stall <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_flux4 got, want;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("virtual_pipe_flux_update_unit regression: fail");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[123:0];
                if (exp_fluxes.size() == 0) begin
                    $error("unexpected transaction on m_axis, data %h", got);
                    fail_cnt++;
                end else begin
                    want = exp_fluxes.pop_front();
                    if (got[0] !== want[0]) begin
                        $error("new_flux_left exp %h got %h", want[0], got[0]);
                        fail_cnt++;
                    end
                    if (got[1] !== want[1]) begin
                        $error("new_flux_up exp %h got %h", want[1], got[1]);
                        fail_cnt++;
                    end
                    if (got[2] !== want[2]) begin
                        $error("new_flux_right exp %h got %h", want[2], got[2]);
                        fail_cnt++;
                    end
                    if (got[3] !== want[3]) begin
                        $error("new_flux_down exp %h got %h", want[3], got[3]);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    initial begin
        fail_cnt = 0;
        idle_cycles = 0;
        calm = 1'b0;
        cfg_gravity = GRAVITY_RST;
        cfg_length = PIPE_LENGTH_RST;
        cfg_radius = PIPE_RADIUS_RST;
        cfg_dt = TIME_STEP_RST;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(4'h0, 32'h0, 32'h0, 31'h0, '0, '0, 1'b1, '0);
        add_row(4'h0, 32'h0, 32'h0, 31'h0, '0, {4{FLUX_MAX}}, 1'b1, '0);
        add_row(4'h0, 32'h0, 32'h0, FLUX_MAX, '0, {4{FLUX_MAX}}, 1'b1, {4{FLUX_MAX}});
        add_row(4'hF, 32'h8000_0000, 32'h8000_0000, 31'h0, {4{32'h7FFF_FFFF}}, '0, 1'b1, '0);
        add_row(4'hF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, FLUX_MAX, {4{32'h8000_0000}}, '0, 1'b0, '0);
        add_row(4'hF, 32'h0001_0000, 32'h0, 31'h0000_8000,
                {32'h0, 32'h0002_0000, 32'hFFFF_0000, 32'h0001_8000},
                {31'h100, 31'h0, 31'h4000, 31'h0}, 1'b0, '0);
        add_row(4'h1, 32'h0, 32'h0001_0000, 31'h0001_0000,
                {4{32'hFFF0_0000}}, {4{31'h10}}, 1'b0, '0);
        add_row(4'h2, 32'h0, 32'h0001_0000, 31'h0001_0000,
                {4{32'hFFF0_0000}}, {4{31'h10}}, 1'b0, '0);
        add_row(4'h4, 32'h0, 32'h0001_0000, 31'h0001_0000,
                {4{32'hFFF0_0000}}, {4{31'h10}}, 1'b0, '0);
        add_row(4'h8, 32'h0, 32'h0001_0000, 31'h0001_0000,
                {4{32'hFFF0_0000}}, {4{31'h10}}, 1'b0, '0);
        add_row(4'hA, 32'h7FFF_FFFF, 32'h0, 31'h0000_0001,
                {32'h8000_0000, 32'h0, 32'h8000_0000, 32'h0}, {4{FLUX_MAX}}, 1'b0, '0);
        foreach (dir_cells[i]) send_cell(dir_cells[i], dir_typed[i], dir_fluxes[i]);

        random_phase(55, 1'b0);
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_phase(55, 1'b0);
        set_config(32'h0, 32'h0, 32'h0, 32'h0);
        random_phase(55, 1'b1);
        set_config(32'h0009_CCCD, 32'h0, 32'h0004_0000, 32'h0);
        random_phase(55, 1'b0);
        set_config(32'h0009_CCCD, 32'h0000_0001, 32'h0002_0000, 32'hFFFF_FFFF);
        random_phase(55, 1'b0);
        set_config(32'h0009_CCCD, 32'h0001_0000, 32'h0004_0000, 32'h1000_0000);
        random_phase(55, 1'b0);
        set_config($urandom, $urandom, $urandom_range(0, 32'h000F_FFFF), $urandom);
        random_phase(55, 1'b0);
        set_config(GRAVITY_RST, PIPE_LENGTH_RST, PIPE_RADIUS_RST, TIME_STEP_RST);
        random_phase(55, 1'b0);

        drain();
        if (fail_cnt == 0) begin
            $display("virtual_pipe_flux_update_unit regression: pass");
        end else begin
            $display("virtual_pipe_flux_update_unit regression: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/vpfu_pkg.sv
sv/virtual_pipe_flux_update_unit.sv
sv/vpfu_checker.sv
verif/tb.sv
